[src/msre_pkg.sv]
// ============================================================================
// msre_pkg - shared types and constants of the matrix swap/rotate engine
// Request codes, field widths, datapath command codes and status bundle.
// ============================================================================
package msre_pkg;

    localparam int MAX_DIM_DEF = 128;

    localparam int DIM_W      = 8;
    localparam int VAL_W      = 32;
    localparam int REQ_W      = 3;
    localparam int CELL_IDX_W = 7;
    localparam int SWAP_IDX_W = 8;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    localparam logic [REQ_W-1:0] REQ_LOAD      = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SWAP_ROWS = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SWAP_COLS = 3'd2;
    localparam logic [REQ_W-1:0] REQ_ROTATE    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    typedef enum logic [3:0] {
        DP_NONE   = 4'd0,
        DP_ACCEPT = 4'd1,
        DP_SW_RD  = 4'd2,
        DP_SW_WA  = 4'd3,
        DP_SW_WB  = 4'd4,
        DP_CP_RD  = 4'd5,
        DP_CP_WR  = 4'd6,
        DP_RT_RD  = 4'd7,
        DP_RT_WR  = 4'd8,
        DP_FINISH = 4'd9
    } dp_op_t;

    typedef struct packed {
        logic go_swap;
        logic go_rot;
        logic swap_done;
        logic walk_done;
    } dp_stat_t;

endpackage

[src/msre_regs.sv]
// ============================================================================
// msre_regs - configuration registers behind the APB port
// Holds row_count and col_count; zero-wait writes, combinational reads.
// ============================================================================
module msre_regs
    import msre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [DIM_W-1:0]  row_cfg,
    output logic [DIM_W-1:0]  col_cfg
);

    logic [DIM_W-1:0] row_cfg_reg;
    logic [DIM_W-1:0] col_cfg_reg;
    logic             reg_sel;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cfg_reg <= DIM_W'(1);
            col_cfg_reg <= DIM_W'(1);
        end
        else if (wr_en)
        begin
            if (reg_sel == REG_ROW_COUNT)
            begin
                row_cfg_reg <= pwdata[DIM_W-1:0];
            end
            else
            begin
                col_cfg_reg <= pwdata[DIM_W-1:0];
            end
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ROW_COUNT: prdata = APB_DW'(row_cfg_reg);
            REG_COL_COUNT: prdata = APB_DW'(col_cfg_reg);
            default:       prdata = '0;
        endcase
    end

    assign row_cfg = row_cfg_reg;
    assign col_cfg = col_cfg_reg;

endmodule

[src/msre_dpath.sv]
// ============================================================================
// msre_dpath - datapath of the matrix swap/rotate engine
// Cell and scratch memories, walk counters, argument checks, result register.
// ============================================================================
module msre_dpath
    import msre_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  dp_op_t                  op,
    output dp_stat_t                stat,
    input  logic [DIM_W-1:0]        row_cfg,
    input  logic [DIM_W-1:0]        col_cfg,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [CELL_IDX_W-1:0]   row_index,
    input  logic [CELL_IDX_W-1:0]   col_index,
    input  logic signed [VAL_W-1:0] cell_value,
    input  logic [SWAP_IDX_W-1:0]   first_index,
    input  logic [SWAP_IDX_W-1:0]   second_index,
    output logic                    status,
    output logic signed [VAL_W-1:0] read_value,
    output logic [DIM_W-1:0]        rows_now,
    output logic [DIM_W-1:0]        cols_now
);

    localparam int IDX_W = $clog2(MAX_DIM);
    localparam int CW    = (IDX_W + 1 > DIM_W) ? IDX_W + 1 : DIM_W;
    localparam int AW    = 2 * IDX_W;
    localparam int DEPTH = 1 << AW;

    logic [VAL_W-1:0] cell_mem [DEPTH];
    logic [VAL_W-1:0] scr_mem  [DEPTH];

    logic             turned_odd_reg;
    logic [IDX_W-1:0] i_reg;
    logic [IDX_W-1:0] j_reg;
    logic [IDX_W-1:0] a_reg;
    logic [IDX_W-1:0] b_reg;
    logic [REQ_W-1:0] req_reg;
    logic             bad_reg;
    logic             row_swap_reg;
    logic [VAL_W-1:0] rda_reg;
    logic [VAL_W-1:0] rdb_reg;
    logic [VAL_W-1:0] scr_rd_reg;

    logic             status_reg;
    logic [VAL_W-1:0] read_value_reg;
    logic [DIM_W-1:0] rows_now_reg;
    logic [DIM_W-1:0] cols_now_reg;

    logic [DIM_W-1:0] rows_cur;
    logic [DIM_W-1:0] cols_cur;
    logic [DIM_W-1:0] swap_lim;
    logic [DIM_W-1:0] walk_lim;
    logic             a_ok;
    logic             b_ok;
    logic             cell_ok;
    logic             is_swap;
    logic             bad;
    logic             sw_last;
    logic             j_last;
    logic             rt_last;

    logic [IDX_W-1:0] ri_idx;
    logic [IDX_W-1:0] ci_idx;
    logic [AW-1:0]    x_addr;
    logic [AW-1:0]    y_addr;
    logic [AW-1:0]    ij_addr;
    logic [AW-1:0]    rot_addr;

    logic             cell_we;
    logic [AW-1:0]    cell_wa;
    logic [VAL_W-1:0] cell_wd;
    logic             rda_en;
    logic [AW-1:0]    rda_addr;
    logic             rdb_en;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (CW'(v) > CW'(MAX_DIM))
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Current dimensions follow the rotation parity.
    assign rows_cur = clamp_dim(turned_odd_reg ? col_cfg : row_cfg);
    assign cols_cur = clamp_dim(turned_odd_reg ? row_cfg : col_cfg);

    // Argument checks on the incoming beat.
    assign is_swap  = (req_type == REQ_SWAP_ROWS) || (req_type == REQ_SWAP_COLS);
    assign swap_lim = (req_type == REQ_SWAP_ROWS) ? rows_cur : cols_cur;
    assign a_ok     = (first_index != '0) && (first_index <= swap_lim);
    assign b_ok     = (second_index != '0) && (second_index <= swap_lim);
    assign cell_ok  = (DIM_W'(row_index) < rows_cur) && (DIM_W'(col_index) < cols_cur);

    always_comb
    begin
        unique case (req_type)
            REQ_LOAD, REQ_READ:           bad = !cell_ok;
            REQ_SWAP_ROWS, REQ_SWAP_COLS: bad = !(a_ok && b_ok);
            REQ_ROTATE:                   bad = 1'b0;
            default:                      bad = 1'b1;
        endcase
    end

    assign ri_idx = IDX_W'(row_index);
    assign ci_idx = IDX_W'(col_index);

    // Walk limits and end flags.
    assign walk_lim = row_swap_reg ? cols_cur : rows_cur;
    assign sw_last  = CW'(j_reg) == (CW'(walk_lim) - CW'(1));
    assign j_last   = CW'(j_reg) == (CW'(cols_cur) - CW'(1));
    assign rt_last  = j_last && (CW'(i_reg) == (CW'(rows_cur) - CW'(1)));

    assign stat.go_swap   = is_swap && a_ok && b_ok;
    assign stat.go_rot    = (req_type == REQ_ROTATE);
    assign stat.swap_done = sw_last;
    assign stat.walk_done = rt_last;

    // Addresses: row in the upper half, column in the lower half.
    assign x_addr   = row_swap_reg ? {a_reg, j_reg} : {j_reg, a_reg};
    assign y_addr   = row_swap_reg ? {b_reg, j_reg} : {j_reg, b_reg};
    assign ij_addr  = {i_reg, j_reg};
    assign rot_addr = {j_reg, IDX_W'(CW'(rows_cur) - CW'(1) - CW'(i_reg))};

    always_comb
    begin
        cell_we  = 1'b0;
        cell_wa  = ij_addr;
        cell_wd  = rda_reg;
        rda_en   = 1'b0;
        rda_addr = ij_addr;
        rdb_en   = 1'b0;
        unique case (op)
            DP_ACCEPT:
            begin
                cell_we  = (req_type == REQ_LOAD) && !bad;
                cell_wa  = {ri_idx, ci_idx};
                cell_wd  = cell_value;
                rda_en   = 1'b1;
                rda_addr = {ri_idx, ci_idx};
            end
            DP_SW_RD:
            begin
                rda_en   = 1'b1;
                rda_addr = x_addr;
                rdb_en   = 1'b1;
            end
            DP_SW_WA:
            begin
                cell_we = 1'b1;
                cell_wa = x_addr;
                cell_wd = rdb_reg;
            end
            DP_SW_WB:
            begin
                cell_we = 1'b1;
                cell_wa = y_addr;
                cell_wd = rda_reg;
            end
            DP_CP_RD:
            begin
                rda_en = 1'b1;
            end
            DP_RT_WR:
            begin
                cell_we = 1'b1;
                cell_wa = rot_addr;
                cell_wd = scr_rd_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[cell_wa] <= cell_wd;
        end
        if (rda_en)
        begin
            rda_reg <= cell_mem[rda_addr];
        end
        if (rdb_en)
        begin
            rdb_reg <= cell_mem[y_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == DP_CP_WR)
        begin
            scr_mem[ij_addr] <= rda_reg;
        end
        if (op == DP_RT_RD)
        begin
            scr_rd_reg <= scr_mem[ij_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turned_odd_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
        end
        else
        begin
            unique case (op)
                DP_ACCEPT:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                end
                DP_SW_WB:
                begin
                    j_reg <= sw_last ? '0 : j_reg + IDX_W'(1);
                end
                DP_CP_WR, DP_RT_WR:
                begin
                    // advance in row order, wrap to the origin at the end
                    if (j_last)
                    begin
                        j_reg <= '0;
                        i_reg <= rt_last ? '0 : i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                    if (op == DP_RT_WR && rt_last)
                    begin
                        turned_odd_reg <= !turned_odd_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == DP_ACCEPT)
        begin
            req_reg      <= req_type;
            bad_reg      <= bad;
            row_swap_reg <= (req_type == REQ_SWAP_ROWS);
            a_reg        <= IDX_W'(first_index - SWAP_IDX_W'(1));
            b_reg        <= IDX_W'(second_index - SWAP_IDX_W'(1));
        end
        if (op == DP_FINISH)
        begin
            status_reg     <= bad_reg;
            read_value_reg <= (req_reg == REQ_READ && !bad_reg) ? rda_reg : '0;
            rows_now_reg   <= rows_cur;
            cols_now_reg   <= cols_cur;
        end
    end

    assign status     = status_reg;
    assign read_value = read_value_reg;
    assign rows_now   = rows_now_reg;
    assign cols_now   = cols_now_reg;

endmodule

[src/msre_ctrl.sv]
// ============================================================================
// msre_ctrl - sequencer of the matrix swap/rotate engine
// Accepts one request at a time, steps the datapath, owns the result valid.
// ============================================================================
module msre_ctrl
    import msre_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_op_t   op,
    input  dp_stat_t stat
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SW_RD  = 9'b000000010,
        ST_SW_WA  = 9'b000000100,
        ST_SW_WB  = 9'b000001000,
        ST_CP_RD  = 9'b000010000,
        ST_CP_WR  = 9'b000100000,
        ST_RT_RD  = 9'b001000000,
        ST_RT_WR  = 9'b010000000,
        ST_FINISH = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        op             = DP_NONE;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op = DP_ACCEPT;
                    priority if (stat.go_swap)
                    begin
                        state_next = ST_SW_RD;
                    end
                    else if (stat.go_rot)
                    begin
                        state_next = ST_CP_RD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SW_RD:
            begin
                op         = DP_SW_RD;
                state_next = ST_SW_WA;
            end
            ST_SW_WA:
            begin
                op         = DP_SW_WA;
                state_next = ST_SW_WB;
            end
            ST_SW_WB:
            begin
                op         = DP_SW_WB;
                state_next = stat.swap_done ? ST_FINISH : ST_SW_RD;
            end
            ST_CP_RD:
            begin
                op         = DP_CP_RD;
                state_next = ST_CP_WR;
            end
            ST_CP_WR:
            begin
                op         = DP_CP_WR;
                state_next = stat.walk_done ? ST_RT_RD : ST_CP_RD;
            end
            ST_RT_RD:
            begin
                op         = DP_RT_RD;
                state_next = ST_RT_WR;
            end
            ST_RT_WR:
            begin
                op         = DP_RT_WR;
                state_next = stat.walk_done ? ST_FINISH : ST_RT_RD;
            end
            ST_FINISH:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    op             = DP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_finish_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_valid_reg && !out_ready)
        |=> (state_reg == ST_FINISH && out_valid_reg))
        else $error("result overwritten while output beat stalled");

    a_swap_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && stat.go_swap) |=> (state_reg == ST_SW_RD))
        else $error("valid swap did not start its walk");

    a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result valid raised outside finish state");

endmodule

[src/matrix_swap_rotate_engine.sv]
// Before result valid: load, read and rejected requests go straight to the finish state;
// a swap walks L cell pairs (L = cols for rows, rows for columns), read, then two writes;
// a rotation of R x C does a copy pass, then a rotate pass, per cell a read, then a write.
// One request in flight; in_ready returns as the result is registered.
// Swap cells need two writes on the single write port; rotation steps read, then write.
// Reset clears control state and sets both counts to 1; the store is not cleared.
// ============================================================================
// matrix_swap_rotate_engine - top level
// Holds a matrix in on-chip memory; loads, reads, row/column swaps, rotation.
// ============================================================================
module matrix_swap_rotate_engine
    import msre_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_AW-1:0]       paddr,
    input  logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [REQ_W-1:0]        req_type,
    input  logic [CELL_IDX_W-1:0]   row_index,
    input  logic [CELL_IDX_W-1:0]   col_index,
    input  logic signed [VAL_W-1:0] cell_value,
    input  logic [SWAP_IDX_W-1:0]   first_index,
    input  logic [SWAP_IDX_W-1:0]   second_index,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    status,
    output logic signed [VAL_W-1:0] read_value,
    output logic [DIM_W-1:0]        rows_now,
    output logic [DIM_W-1:0]        cols_now
);

    logic [DIM_W-1:0] row_cfg;
    logic [DIM_W-1:0] col_cfg;
    dp_op_t           op;
    dp_stat_t         stat;

    msre_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .row_cfg (row_cfg),
        .col_cfg (col_cfg)
    );

    msre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .op        (op),
        .stat      (stat)
    );

    msre_dpath #(
        .MAX_DIM (MAX_DIM)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .stat         (stat),
        .row_cfg      (row_cfg),
        .col_cfg      (col_cfg),
        .req_type     (req_type),
        .row_index    (row_index),
        .col_index    (col_index),
        .cell_value   (cell_value),
        .first_index  (first_index),
        .second_index (second_index),
        .status       (status),
        .read_value   (read_value),
        .rows_now     (rows_now),
        .cols_now     (cols_now)
    );

endmodule
